// File: hw/rtl/sgef_pkg.sv
// Shared types and constants of the edge-padded smoothing FIR.
// Used by every module of the block; depends on nothing.
package sgef_pkg;

	// Defaults of the top-level parameters
	localparam int DEF_MAX_SIDE       = 11;
	localparam int DEF_SAMPLE_BITS    = 32;
	localparam int DEF_COEF_FRAC_BITS = 14;

	// Coefficient storage: four signed taps per bank word
	localparam int NUM_BANKS     = 6;
	localparam int BANK_IDX_BITS = $clog2(NUM_BANKS);
	localparam int COEF_BITS     = 16;
	localparam int TAP_IDX_BITS  = 6;
	localparam int ACC_BITS      = 64;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int SIDE_REG_BITS = 4;

	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BANK0 = 3'd2;

	localparam logic [CFG_DATA_BITS-1:0] BANK0_RESET = 64'd16384;

	typedef struct packed {
		logic load_all;
		logic shift;
	} win_ctl_t;

	typedef struct packed {
		logic clr;
		logic issue;
		logic round;
		logic clamp;
	} mac_ctl_t;

endpackage

// File: hw/rtl/savgol_edge_padded_fir_unit.sv
// Edge-padded smoothing FIR: one sample in, filtered samples out.
// Depends on sgef_pkg, sgef_window, sgef_mac and sgef_ctrl.
//
// Input channel (in_valid/in_stall) takes one sample beat with a last flag
// per spectrum end. Output channel (out_valid/out_stall) gives smoothed,
// clipped and final_res beats. The first sample of a spectrum is repeated
// left_points times before the data; the last is repeated right_points
// times after it. Output for position i leaves once sample i+right_points
// is in; a last beat flushes every pending output, final_res on the end.
// Configuration (cfg_we/cfg_index/cfg_data) is to be written while idle
// by the user; the block itself does not enforce this.
//
// The filter has T = left_points + right_points + 1 taps. One shared
// 16 x SAMPLE_BITS multiplier walks the taps at one per cycle.
// A finished result waits in the output register while the next beat is
// accepted; a stalled output only holds the block once the next result
// is ready. Reset clears the sequencer and output valid and loads the
// default taps (identity filter, zero side points); the window has no reset.
module savgol_edge_padded_fir_unit
	import sgef_pkg::*;
#(
	parameter int MAX_SIDE       = DEF_MAX_SIDE,
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SAMPLE_BITS-1:0]   sample,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [SAMPLE_BITS-1:0]   smoothed,
	output logic                     clipped,
	output logic                     final_res
);

	localparam int WIN_DEPTH = 2 * MAX_SIDE + 1;
	localparam int SW        = $clog2(MAX_SIDE + 1);
	localparam int IW        = $clog2(WIN_DEPTH);

	logic [SIDE_REG_BITS-1:0] left_q;
	logic [SIDE_REG_BITS-1:0] right_q;
	logic [CFG_DATA_BITS-1:0] coef_q [NUM_BANKS];

	logic [CFG_IDX_BITS-1:0]  bank_wr;
	logic [SW-1:0]            nl;
	logic [SW-1:0]            nr;
	logic [TAP_IDX_BITS-1:0]  tap_k;
	logic [TAP_IDX_BITS-3:0]  bank_sel;
	logic signed [COEF_BITS-1:0] coef;

	win_ctl_t               win_ctl;
	mac_ctl_t               mac_ctl;
	logic [SAMPLE_BITS-1:0] win_din;
	logic [SAMPLE_BITS-1:0] win_data;
	logic [IW-1:0]          win_idx;
	logic [IW-1:0]          tap_idx;
	logic [SAMPLE_BITS-1:0] mac_res;
	logic                   mac_clip;

	assign bank_wr = cfg_index - REG_BANK0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
			for (int i = 0; i < NUM_BANKS; i++) begin
				coef_q[i] <= (i == 0) ? BANK0_RESET : '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:  left_q  <= cfg_data[SIDE_REG_BITS-1:0];
				REG_RIGHT: right_q <= cfg_data[SIDE_REG_BITS-1:0];
				default: begin
					if (int'(bank_wr) < NUM_BANKS) begin
						coef_q[bank_wr[BANK_IDX_BITS-1:0]] <= cfg_data;
					end
				end
			endcase
		end
	end

	// Clamp side counts to the window size
	always_comb begin
		nl = (int'(left_q) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(left_q);
		nr = (int'(right_q) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(right_q);
	end

	// Tap k sits at bits 16*(k%4) of bank k/4; taps past the banks are zero
	always_comb begin
		tap_k    = TAP_IDX_BITS'(tap_idx);
		bank_sel = tap_k[TAP_IDX_BITS-1:2];
		if (int'(bank_sel) < NUM_BANKS) begin
			coef = coef_q[bank_sel[BANK_IDX_BITS-1:0]][COEF_BITS*tap_k[1:0] +: COEF_BITS];
		end else begin
			coef = '0;
		end
	end

	sgef_window #(
		.DEPTH (WIN_DEPTH),
		.WIDTH (SAMPLE_BITS)
	) u_window (
		.clk     (clk),
		.ctl     (win_ctl),
		.din     (win_din),
		.rd_idx  (win_idx),
		.rd_data (win_data)
	);

	sgef_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.coef     (coef),
		.din      (win_data),
		.res      (mac_res),
		.res_clip (mac_clip)
	);

	sgef_ctrl #(
		.MAX_SIDE    (MAX_SIDE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.smoothed  (smoothed),
		.clipped   (clipped),
		.final_res (final_res),
		.nl        (nl),
		.nr        (nr),
		.win_ctl   (win_ctl),
		.win_din   (win_din),
		.win_idx   (win_idx),
		.tap_idx   (tap_idx),
		.mac_ctl   (mac_ctl),
		.mac_res   (mac_res),
		.mac_clip  (mac_clip)
	);

endmodule

// File: hw/rtl/sgef_window.sv
// Sample window of the smoothing FIR: a shift line with a full-fill load.
// Depends on sgef_pkg for the control struct.
module sgef_window
	import sgef_pkg::*;
#(
	parameter int DEPTH = 2 * DEF_MAX_SIDE + 1,
	parameter int WIDTH = DEF_SAMPLE_BITS
) (
	input  logic                     clk,
	input  win_ctl_t                 ctl,
	input  logic [WIDTH-1:0]         din,
	input  logic [$clog2(DEPTH)-1:0] rd_idx,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] win_q [DEPTH];

	// First sample of a spectrum fills every slot (left padding)
	always_ff @(posedge clk) begin
		if (ctl.load_all) begin
			for (int i = 0; i < DEPTH; i++) begin
				win_q[i] <= din;
			end
		end else if (ctl.shift) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[DEPTH-1] <= din;
		end
	end

	assign rd_data = win_q[rd_idx];

endmodule

// File: hw/rtl/sgef_mac.sv
// Shared multiply-accumulate of the smoothing FIR, with rounding and clamp.
// Depends on sgef_pkg for widths and the control struct.
module sgef_mac
	import sgef_pkg::*;
#(
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctl_t                      ctl,
	input  logic signed [COEF_BITS-1:0]   coef,
	input  logic signed [SAMPLE_BITS-1:0] din,
	output logic [SAMPLE_BITS-1:0]        res,
	output logic                          res_clip
);

	localparam int PW = COEF_BITS + SAMPLE_BITS;
	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
	localparam logic signed [ACC_BITS-1:0] HALF =
		ACC_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
	localparam logic signed [ACC_BITS-1:0] OUT_MAX =
		ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_BITS-1:0] OUT_MIN = -OUT_MAX - 64'sd1;

	logic signed [PW-1:0]       prod_s1;
	logic                       prod_vld_s1;
	logic signed [ACC_BITS-1:0] acc_q;
	logic                       clip_q;
	logic [SAMPLE_BITS-1:0]     res_q;
	logic                       res_clip_q;

	logic signed [ACC_BITS-1:0] addend;
	logic signed [ACC_BITS:0]   sum;
	logic                       ovf;
	logic signed [ACC_BITS-1:0] sum_sat;
	logic signed [ACC_BITS-1:0] q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * din;
	end

	// One saturating adder serves the taps and the rounding constant
	always_comb begin
		addend  = prod_vld_s1 ? ACC_BITS'(prod_s1) : HALF;
		sum     = {acc_q[ACC_BITS-1], acc_q} + {addend[ACC_BITS-1], addend};
		ovf     = sum[ACC_BITS] ^ sum[ACC_BITS-1];
		sum_sat = ovf ? (sum[ACC_BITS] ? ACC_MIN : ACC_MAX) : sum[ACC_BITS-1:0];
		q       = acc_q >>> COEF_FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
		end else if (prod_vld_s1 || ctl.round) begin
			acc_q  <= sum_sat;
			clip_q <= clip_q | ovf;
		end
		if (ctl.clamp) begin
			if (q > OUT_MAX) begin
				res_q      <= OUT_MAX[SAMPLE_BITS-1:0];
				res_clip_q <= 1'b1;
			end else if (q < OUT_MIN) begin
				res_q      <= OUT_MIN[SAMPLE_BITS-1:0];
				res_clip_q <= 1'b1;
			end else begin
				res_q      <= q[SAMPLE_BITS-1:0];
				res_clip_q <= clip_q;
			end
		end
	end

	assign res      = res_q;
	assign res_clip = res_clip_q;

endmodule

// File: hw/rtl/sgef_ctrl.sv
// Sequencer of the smoothing FIR: window padding, output count, tap loop,
// and the output register. Depends on sgef_pkg.
module sgef_ctrl
	import sgef_pkg::*;
#(
	parameter  int MAX_SIDE    = DEF_MAX_SIDE,
	parameter  int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int WIN_DEPTH   = 2 * MAX_SIDE + 1,
	localparam int SW          = $clog2(MAX_SIDE + 1),
	localparam int IW          = $clog2(WIN_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] smoothed,
	output logic                   clipped,
	output logic                   final_res,
	input  logic [SW-1:0]          nl,
	input  logic [SW-1:0]          nr,
	output win_ctl_t               win_ctl,
	output logic [SAMPLE_BITS-1:0] win_din,
	output logic [IW-1:0]          win_idx,
	output logic [IW-1:0]          tap_idx,
	output mac_ctl_t               mac_ctl,
	input  logic [SAMPLE_BITS-1:0] mac_res,
	input  logic                   mac_clip
);

	localparam int CW = $clog2(MAX_SIDE + 2);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_CHECK = 4'd2;
	localparam logic [3:0] ST_FLUSH = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_DRAIN = 4'd5;
	localparam logic [3:0] ST_ROUND = 4'd6;
	localparam logic [3:0] ST_CLAMP = 4'd7;
	localparam logic [3:0] ST_PUT   = 4'd8;

	logic [3:0]             state_q;
	logic [CW-1:0]          seen_q;
	logic                   in_spec_q;
	logic                   last_q;
	logic                   fin_q;
	logic [IW-1:0]          k_q;
	logic [SAMPLE_BITS-1:0] x_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] smoothed_q;
	logic                   clipped_q;
	logic                   final_q;

	logic          emit_now;
	logic          put_fire;
	logic [IW-1:0] k_end;

	always_comb begin
		emit_now = seen_q > CW'(nr);
		put_fire = (state_q == ST_PUT) && (!out_valid_q || !out_stall);
		k_end    = IW'(nl) + IW'(nr);

		win_ctl.load_all = (state_q == ST_LOAD) && !in_spec_q;
		win_ctl.shift    = ((state_q == ST_LOAD) && in_spec_q) ||
		                   ((state_q == ST_FLUSH) && (seen_q != '0));

		mac_ctl.clr   = ((state_q == ST_CHECK) && emit_now) ||
		                ((state_q == ST_FLUSH) && (seen_q != '0));
		mac_ctl.issue = (state_q == ST_MUL);
		mac_ctl.round = (state_q == ST_ROUND);
		mac_ctl.clamp = (state_q == ST_CLAMP);
	end

	assign win_din = x_q;
	assign win_idx = IW'(WIN_DEPTH - 1) - IW'(nr) - IW'(nl) + k_q;
	assign tap_idx = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= '0;
			in_spec_q   <= 1'b0;
			last_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (put_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q  <= last;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					seen_q    <= in_spec_q ? CW'(seen_q + CW'(1)) : CW'(1);
					in_spec_q <= 1'b1;
					state_q   <= ST_CHECK;
				end
				ST_CHECK: begin
					if (emit_now) begin
						seen_q  <= CW'(seen_q - CW'(1));
						k_q     <= '0;
						state_q <= ST_MUL;
					end else begin
						state_q <= last_q ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					// Each flushed output shifts in one more copy of the last sample
					if (seen_q != '0) begin
						seen_q  <= CW'(seen_q - CW'(1));
						k_q     <= '0;
						state_q <= ST_MUL;
					end else begin
						in_spec_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				ST_MUL: begin
					k_q <= IW'(k_q + IW'(1));
					if (k_q == k_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_PUT;
				ST_PUT: begin
					if (put_fire) begin
						state_q <= last_q ? ST_FLUSH : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			x_q <= sample;
		end
		if (state_q == ST_CHECK) begin
			fin_q <= last_q && (seen_q == CW'(1));
		end else if (state_q == ST_FLUSH) begin
			fin_q <= (seen_q == CW'(1));
		end
		if (put_fire) begin
			smoothed_q <= mac_res;
			clipped_q  <= mac_clip;
			final_q    <= fin_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign smoothed  = smoothed_q;
	assign clipped   = clipped_q;
	assign final_res = final_q;

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CW'(MAX_SIDE + 1))
		else $error("pending output count out of range");

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && in_valid |=> (state_q == ST_LOAD))
		else $error("accepted beat not loaded into window");

	a_final_empty: assert property (@(posedge clk) disable iff (!arst_n)
		put_fire && fin_q |-> (seen_q == '0))
		else $error("final result sent with outputs still pending");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (k_q <= k_end))
		else $error("tap counter ran past the window");

endmodule

// File: tb/savgol_edge_padded_fir_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the edge-padded smoothing FIR (savgol_edge_padded_fir_unit).
// Holds a bit-exact filter predictor and a directed table followed by random spectra.
// Depends on sgef_pkg and the RTL top level only.
module savgol_edge_padded_fir_unit_test;
	import sgef_pkg::*;

	localparam int     WIN_DEPTH   = 2 * DEF_MAX_SIDE + 1;
	localparam longint SMP_MAX     = (longint'(1) <<< (DEF_SAMPLE_BITS - 1)) - 1;
	localparam longint SMP_MIN     = -SMP_MAX - 1;
	localparam int     CYCLE_LIMIT = 1000000;
	localparam int     HOLD_CYCLES = 300;
	localparam int     DRAIN_WAIT  = 40;
	localparam int     PHASES      = 8;
	localparam int     PHASE_BEATS = 29;

	typedef struct packed {
		logic [DEF_SAMPLE_BITS-1:0] smoothed;
		logic                       clipped;
		logic                       final_res;
	} result_t;

	typedef enum logic [1:0] {S_ID, S_NEG2, S_WIDE, S_CLAMP} filt_setting_t;
	typedef enum logic [1:0] {COEF_FULL, COEF_SMALL, COEF_EDGE} coef_mix_t;

	typedef struct packed {
		filt_setting_t              setting;
		logic                       fresh_cfg;
		logic [DEF_SAMPLE_BITS-1:0] smp;
		logic                       fin;
		logic                       typed;
		result_t                    want;
	} plan_row_t;

	// Identity filter after reset, then tap0 = -2.0, then the widest window,
	// then a left side count above the maximum.
	localparam plan_row_t DIRECTED [24] = '{
		'{S_ID,    1'b0, 32'h00000000, 1'b0, 1'b1, '{32'h00000000, 1'b0, 1'b0}},
		'{S_ID,    1'b0, 32'h7FFFFFFF, 1'b0, 1'b1, '{32'h7FFFFFFF, 1'b0, 1'b0}},
		'{S_ID,    1'b0, 32'h80000000, 1'b0, 1'b1, '{32'h80000000, 1'b0, 1'b0}},
		'{S_ID,    1'b0, 32'hFFFFFFFF, 1'b1, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b1}},
		'{S_ID,    1'b0, 32'h12345678, 1'b1, 1'b1, '{32'h12345678, 1'b0, 1'b1}},
		'{S_NEG2,  1'b1, 32'h80000000, 1'b0, 1'b1, '{32'h7FFFFFFF, 1'b1, 1'b0}},
		'{S_NEG2,  1'b0, 32'h00000003, 1'b0, 1'b1, '{32'hFFFFFFFA, 1'b0, 1'b0}},
		'{S_NEG2,  1'b0, 32'h7FFFFFFF, 1'b1, 1'b1, '{32'h80000000, 1'b1, 1'b1}},
		'{S_WIDE,  1'b1, 32'h00001000, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'hFFFFF000, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'h7FFFFFFF, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'h80000000, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'h00000001, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'h0000FFFF, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'hFFFF0000, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'h00123456, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'hFFEDCBA9, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'h00000000, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'h55555555, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'hAAAAAAAA, 1'b0, 1'b0, '0},
		'{S_WIDE,  1'b0, 32'h0000ABCD, 1'b1, 1'b0, '0},
		'{S_CLAMP, 1'b1, 32'h00000100, 1'b0, 1'b0, '0},
		'{S_CLAMP, 1'b0, 32'hFFFFFE00, 1'b0, 1'b0, '0},
		'{S_CLAMP, 1'b0, 32'h00000300, 1'b1, 1'b0, '0}
	};

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic [DEF_SAMPLE_BITS-1:0] sample    = '0;
	logic                       last      = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [DEF_SAMPLE_BITS-1:0] smoothed;
	logic                       clipped;
	logic                       final_res;

	savgol_edge_padded_fir_unit u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Filter predictor state and its copy of the registers
	logic [3:0]               cfg_left  = 4'd0;
	logic [3:0]               cfg_right = 4'd0;
	logic [CFG_DATA_BITS-1:0] cfg_bank [NUM_BANKS] = '{BANK0_RESET, '0, '0, '0, '0, '0};
	longint                   win [WIN_DEPTH];
	int unsigned              pend_cnt = 0;
	logic                     in_spec  = 1'b0;

	result_t smoothed_due [$];
	result_t step_out [$];

	int send_idle_pct  = 24;
	int recv_stall_pct = 58;
	int hold_requests  = 0;
	int holds_done     = 0;
	int mismatch_cnt   = 0;
	int cycle_cnt      = 0;

	function automatic int unsigned side_clamp(logic [3:0] v);
		return (v > DEF_MAX_SIDE) ? DEF_MAX_SIDE : int'(v);
	endfunction

	function automatic void shift_win(longint x);
		for (int i = 0; i < WIN_DEPTH - 1; i++)
			win[i] = win[i + 1];
		win[WIN_DEPTH - 1] = x;
	endfunction

	// One output point from the current window; the 64-bit sum cannot overflow
	// at 16-bit taps, 32-bit samples and 23 points.
	function automatic result_t fir_point(logic fin);
		int unsigned nl, nr, base;
		longint acc, q;
		logic [COEF_BITS-1:0] c;
		result_t r;
		nl = side_clamp(cfg_left);
		nr = side_clamp(cfg_right);
		base = WIN_DEPTH - 1 - nl - nr;
		acc = 0;
		for (int k = 0; k <= int'(nl + nr); k++) begin
			c = cfg_bank[k / 4][(k % 4) * COEF_BITS +: COEF_BITS];
			acc += longint'($signed(c)) * win[base + k];
		end
		acc += longint'(1) <<< (DEF_COEF_FRAC_BITS - 1);
		q = acc >>> DEF_COEF_FRAC_BITS;
		r.clipped = 1'b0;
		if (q > SMP_MAX) begin
			q = SMP_MAX;
			r.clipped = 1'b1;
		end
		if (q < SMP_MIN) begin
			q = SMP_MIN;
			r.clipped = 1'b1;
		end
		r.smoothed = q[DEF_SAMPLE_BITS-1:0];
		r.final_res = fin;
		return r;
	endfunction

	// Advance the predictor by one sample; fills step_out with its outputs.
	function automatic void smooth_sample(logic [DEF_SAMPLE_BITS-1:0] s, logic l);
		longint x;
		int unsigned nr;
		x = longint'($signed(s));
		nr = side_clamp(cfg_right);
		step_out.delete();
		if (!in_spec) begin
			// left padding: the first sample fills the whole window
			foreach (win[i])
				win[i] = x;
			pend_cnt = 1;
			in_spec = 1'b1;
		end else begin
			shift_win(x);
			pend_cnt++;
		end
		if (pend_cnt > nr) begin
			step_out.push_back(fir_point(l && pend_cnt == 1));
			pend_cnt--;
		end
		if (l) begin
			// flush: right padding repeats the last sample
			while (pend_cnt > 0) begin
				shift_win(x);
				pend_cnt--;
				step_out.push_back(fir_point(pend_cnt == 0));
			end
			in_spec = 1'b0;
		end
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] make_bank(coef_mix_t mix);
		logic [CFG_DATA_BITS-1:0] w;
		logic [COEF_BITS-1:0] c;
		w = '0;
		for (int t = 0; t < 4; t++) begin
			case (mix)
				COEF_SMALL: c = COEF_BITS'($urandom_range(0, 4095)) - 16'd2048;
				COEF_EDGE: begin
					case ($urandom_range(0, 3))
						0: c = 16'h7FFF;
						1: c = 16'h8000;
						2: c = 16'h0000;
						default: c = 16'hFFFF;
					endcase
				end
				default: c = COEF_BITS'($urandom);
			endcase
			w[t * COEF_BITS +: COEF_BITS] = c;
		end
		return w;
	endfunction

	function automatic logic [DEF_SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 32'h00000000;
					default: return 32'hFFFFFFFF;
				endcase
			end
			1, 2, 3: return $urandom;
			default: return 32'($urandom_range(0, 200000)) - 32'd100000;
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_LEFT)
			cfg_left = data[3:0];
		else if (idx == REG_RIGHT)
			cfg_right = data[3:0];
		else
			cfg_bank[idx - REG_BANK0] = data;
	endtask

	task automatic load_filter(input logic [3:0] lp, input logic [3:0] rp,
			input logic [CFG_DATA_BITS-1:0] banks [NUM_BANKS]);
		// upper bits of the side registers are don't-care; toggle them anyway
		write_reg(REG_LEFT, {$urandom, 28'($urandom), lp});
		write_reg(REG_RIGHT, {$urandom, 28'($urandom), rp});
		for (int b = 0; b < NUM_BANKS; b++)
			write_reg(REG_BANK0 + CFG_IDX_BITS'(b), banks[b]);
		cfg_we <= 1'b0;
	endtask

	// Hold the input until every output is back, then let a beat with no
	// output finish before touching the registers.
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (smoothed_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic apply_setting(input filt_setting_t sel);
		logic [CFG_DATA_BITS-1:0] banks [NUM_BANKS];
		foreach (banks[b])
			banks[b] = make_bank(sel == S_CLAMP ? COEF_SMALL : COEF_FULL);
		case (sel)
			S_NEG2: begin
				banks[0][COEF_BITS-1:0] = 16'h8000;
				load_filter(4'd0, 4'd0, banks);
			end
			S_WIDE: load_filter(4'd11, 4'd11, banks);
			S_CLAMP: load_filter(4'd14, 4'd3, banks);
			default: begin
				foreach (banks[b])
					banks[b] = '0;
				banks[0] = BANK0_RESET;
				load_filter(4'd0, 4'd0, banks);
			end
		endcase
	endtask

	task automatic offer_sample(input logic [DEF_SAMPLE_BITS-1:0] s, input logic l,
			input logic typed, input result_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		smooth_sample(s, l);
		if (typed) begin
			step_out.delete();
			step_out.push_back(want);
		end
		foreach (step_out[i])
			smoothed_due.push_back(step_out[i]);
	endtask

	// Receiver: check every accepted beat, stall at random, honor hold-off requests
	initial begin
		int hold_cnt;
		result_t got, want;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = {smoothed, clipped, final_res};
				if (smoothed_due.size() == 0) begin
					$display("%0t: unexpected beat smoothed=%h clipped=%b final_res=%b",
						$time, got.smoothed, got.clipped, got.final_res);
					mismatch_cnt++;
				end else begin
					want = smoothed_due.pop_front();
					if (got.smoothed !== want.smoothed) begin
						$display("%0t: smoothed expected %h actual %h",
							$time, want.smoothed, got.smoothed);
						mismatch_cnt++;
					end
					if (got.clipped !== want.clipped) begin
						$display("%0t: clipped expected %b actual %b",
							$time, want.clipped, got.clipped);
						mismatch_cnt++;
					end
					if (got.final_res !== want.final_res) begin
						$display("%0t: final_res expected %b actual %b",
							$time, want.final_res, got.final_res);
						mismatch_cnt++;
					end
				end
			end
			if (hold_cnt == 0 && holds_done != hold_requests) begin
				hold_cnt = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int item_no, span_left;
		logic [3:0] lp, rp;
		coef_mix_t mix;
		logic [CFG_DATA_BITS-1:0] banks [NUM_BANKS];
		span_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].fresh_cfg) begin
				drain_outputs();
				apply_setting(DIRECTED[i].setting);
			end
			offer_sample(DIRECTED[i].smp, DIRECTED[i].fin, DIRECTED[i].typed,
				DIRECTED[i].want);
		end

		// Phases do not wait for a spectrum end, so some settings change mid-spectrum
		for (int p = 0; p < PHASES; p++) begin
			drain_outputs();
			case (p)
				0: begin lp = 4'd0;  rp = 4'd0;  end
				1: begin lp = 4'd15; rp = 4'd15; end
				2: begin lp = 4'd11; rp = 4'd0;  end
				3: begin lp = 4'd0;  rp = 4'd11; end
				default: begin
					lp = 4'($urandom_range(0, 15));
					rp = 4'($urandom_range(0, 15));
				end
			endcase
			mix = coef_mix_t'($urandom_range(0, 2));
			foreach (banks[b])
				banks[b] = make_bank(mix);
			load_filter(lp, rp, banks);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				item_no = p * PHASE_BEATS + n;
				if (item_no < 77) begin
					send_idle_pct = 24;
					recv_stall_pct = 58;
				end else if (item_no < 154) begin
					send_idle_pct = 58;
					recv_stall_pct = 24;
				end else begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				// long receiver hold-off while input keeps coming: backs up the block
				if (item_no == 100)
					hold_requests++;
				if (span_left == 0)
					span_left = $urandom_range(1, 24);
				offer_sample(pick_sample(), span_left == 1, 1'b0, '0);
				span_left--;
			end
		end

		in_valid <= 1'b0;
		while (smoothed_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
